FILE: rtl/pvlc_pkg.sv
// Package with shared types, codes and helpers of the particle vector limit clamp.
package pvlc_pkg;

  // Item function codes on the input channel.
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_POS    = 2'd1;
  localparam logic [1:0] FUNC_VEC    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Vector kinds.
  localparam logic [1:0] KIND_FORCE  = 2'd0;
  localparam logic [1:0] KIND_VEL    = 2'd1;
  localparam logic [1:0] KIND_TORQUE = 2'd2;
  localparam logic [1:0] KIND_ANGMOM = 2'd3;

  // Limiting methods.
  localparam logic [1:0] METH_NONE    = 2'd0;
  localparam logic [1:0] METH_LIMIT   = 2'd1;
  localparam logic [1:0] METH_OVERLAP = 2'd2;
  localparam logic [1:0] METH_DELETE  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_BOX_X_LOW  = 3'd0;
  localparam logic [2:0] REG_BOX_X_HIGH = 3'd1;
  localparam logic [2:0] REG_BOX_Y_LOW  = 3'd2;
  localparam logic [2:0] REG_BOX_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_BOX_Z_LOW  = 3'd4;
  localparam logic [2:0] REG_BOX_Z_HIGH = 3'd5;
  localparam logic [2:0] REG_APPLY_IN   = 3'd6;

  typedef logic signed [31:0] fix_t;

  // Magnitude of a signed Q16.16 value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input fix_t v);
    logic [31:0] neg;
    neg = 32'(-v);
    return v[31] ? neg : 32'(v);
  endfunction

endpackage

FILE: rtl/pvlc_in_if.sv
// Input channel interface: valid, ready and one input item.
interface pvlc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [3:0]        component;
  logic [1:0]        kind;
  logic signed [31:0] elem_a;
  logic signed [31:0] elem_b;
  logic signed [31:0] elem_c;

  modport source (output valid, func, component, kind, elem_a, elem_b, elem_c,
                  input ready);
  modport sink (input valid, func, component, kind, elem_a, elem_b, elem_c,
                output ready);
endinterface

FILE: rtl/pvlc_out_if.sv
// Result channel interface: valid, ready and one result item.
interface pvlc_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic signed [31:0] out_a;
  logic signed [31:0] out_b;
  logic signed [31:0] out_c;
  logic              was_scaled;
  logic              drop_particle;
  logic              last_of_particle;

  modport source (output valid, out_kind, out_a, out_b, out_c, was_scaled,
                  drop_particle, last_of_particle, input ready);
  modport sink (input valid, out_kind, out_a, out_b, out_c, was_scaled,
                drop_particle, last_of_particle, output ready);
endinterface

FILE: rtl/pvlc_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
module pvlc_mul (
  input  logic        clk,
  input  logic [31:0] mul_x,
  input  logic [31:0] mul_y,
  output logic [63:0] prod_r
);

  // The product is registered, so it appears in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_x) * 64'(mul_y);
  end

endmodule

FILE: rtl/pvlc_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module pvlc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done_r,
  output logic [31:0] root_r
);

  logic [63:0] n_r;
  logic [34:0] rem_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        take;

  // One digit of the root: bring down two bits and try to subtract.
  always_comb begin
    rem_sh = {rem_r[32:0], n_r[63:62]};
    trial  = {1'b0, root_r, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      n_r    <= {n_r[61:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[30:0], take};
    end
  end

endmodule

FILE: rtl/pvlc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pvlc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done_r,
  output logic [31:0] quot_r
);

  logic [31:0] rem_r;
  logic [31:0] low_r;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;

  // The dividend's upper half is below the divisor, so 32 steps suffice.
  always_comb begin
    trial = {rem_r, low_r[31]};
    diff  = trial - {1'b0, den_r};
    take  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend[63:32];
      low_r  <= dividend[31:0];
      den_r  <= divisor;
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= take ? diff[31:0] : trial[31:0];
      low_r  <= {low_r[30:0], 1'b0};
      quot_r <= {quot_r[30:0], take};
    end
  end

endmodule

FILE: rtl/particle_vector_limit_clamp_top.sv
// Top level of the particle vector limit clamp: tables, sequencer and result register.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid / ready    func, component, kind, elem_a, elem_b, elem_c
//   out_ch    out  valid / ready    out_kind, out_a, out_b, out_c, flags
//   cfg_*     in   cfg_we           cfg_index, cfg_wdata
//
// Load, position and unused items leave the block idle. An unchecked vector item goes
// straight to finish, a checked one runs the magnitude steps, and a rescaled one also
// uses the shared multiplier, the square root and three divisions. Synchronous reset
// clears the method table, flags and box minimums and sets box maximums to 2^31-1.
// A finished result waits in the output register while the next item is taken;
// a vector item finishing behind a stalled result waits until that beat leaves.
module particle_vector_limit_clamp_top #(
  parameter int NUM_COMPONENTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  pvlc_in_if.sink      in_ch,
  pvlc_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int CIW   = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int LAW   = CIW + 2;
  localparam int LDEPTH = NUM_COMPONENTS * 4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAG, ST_ROOT, ST_MULC, ST_DIVS, ST_DIVW, ST_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers.
  pvlc_pkg::fix_t box_xl_r, box_xh_r, box_yl_r, box_yh_r, box_zl_r, box_zh_r;
  logic           apply_in_r;

  // Tables.
  logic [1:0]  meth_tab_r [NUM_COMPONENTS];
  logic [31:0] lim_mem [LDEPTH];
  logic [31:0] lim_q;

  // Particle flags.
  logic active_r, force_ex_r, torque_ex_r, any_ex_r;

  // Item registers.
  pvlc_pkg::fix_t va_r, vb_r, vc_r, ra_r, rb_r, rc_r;
  logic [1:0]  kind_r, meth_r, sel_r;
  logic [2:0]  cnt_r;
  logic [63:0] acc_r;
  logic        scaled_r, drop_r;

  // Output register.
  logic           out_valid_r;
  logic [1:0]     o_kind_r;
  pvlc_pkg::fix_t o_a_r, o_b_r, o_c_r;
  logic           o_scaled_r, o_drop_r, o_last_r;

  // Shared units.
  logic [31:0] mul_x, mul_y, root;
  logic [63:0] prod;
  logic        root_start, root_done, div_start, div_done;
  logic [31:0] quot;

  logic           accept, comp_ok, in_box, exceeds, do_scale, last, can_load, load_out;
  logic [CIW-1:0] comp_idx;
  logic [LAW-1:0] lim_addr;
  pvlc_pkg::fix_t sel_v, q_signed;

  assign accept   = in_ch.valid && in_ch.ready;
  assign comp_idx = CIW'(in_ch.component);
  assign comp_ok  = 32'(in_ch.component) < 32'(NUM_COMPONENTS);
  assign lim_addr = {comp_idx, in_ch.kind};
  assign last     = kind_r == pvlc_pkg::KIND_ANGMOM;
  assign can_load = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == ST_FINISH) && can_load;

  // Box test: inclusive at each minimum, exclusive at each maximum.
  assign in_box = (in_ch.elem_a >= box_xl_r) && (in_ch.elem_a < box_xh_r) &&
                  (in_ch.elem_b >= box_yl_r) && (in_ch.elem_b < box_yh_r) &&
                  (in_ch.elem_c >= box_zl_r) && (in_ch.elem_c < box_zh_r);

  // Exceedance and the rescale decision, valid on the last magnitude step.
  assign exceeds = !lim_q[31] && (acc_r > prod);
  always_comb begin
    case (meth_r)
      pvlc_pkg::METH_LIMIT:   do_scale = exceeds;
      pvlc_pkg::METH_OVERLAP: begin
        if (kind_r == pvlc_pkg::KIND_VEL) do_scale = exceeds && force_ex_r;
        else if (kind_r == pvlc_pkg::KIND_ANGMOM) do_scale = exceeds && torque_ex_r;
        else do_scale = exceeds;
      end
      default: do_scale = 1'b0;
    endcase
  end

  // Component chosen for the current scaling pass.
  always_comb begin
    case (sel_r)
      2'd0:    sel_v = va_r;
      2'd1:    sel_v = vb_r;
      default: sel_v = vc_r;
    endcase
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_x = pvlc_pkg::mag32(sel_v);
    mul_y = lim_q;
    if (state_r == ST_MAG) begin
      case (cnt_r)
        3'd0:    begin mul_x = pvlc_pkg::mag32(va_r); mul_y = mul_x; end
        3'd1:    begin mul_x = pvlc_pkg::mag32(vb_r); mul_y = mul_x; end
        3'd2:    begin mul_x = pvlc_pkg::mag32(vc_r); mul_y = mul_x; end
        default: begin mul_x = lim_q;                 mul_y = lim_q; end
      endcase
    end
  end

  assign root_start = (state_r == ST_MAG) && (cnt_r == 3'd4) && do_scale;
  assign div_start  = state_r == ST_DIVS;
  assign q_signed   = sel_v[31] ? pvlc_pkg::fix_t'(-quot) : pvlc_pkg::fix_t'(quot);

  pvlc_mul u_mul (.clk(clk), .mul_x(mul_x), .mul_y(mul_y), .prod_r(prod));

  pvlc_isqrt u_root (
    .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(acc_r),
    .done_r(root_done), .root_r(root)
  );

  pvlc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod),
    .divisor(root), .done_r(div_done), .quot_r(quot)
  );

  // Limit table: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (accept && in_ch.func == pvlc_pkg::FUNC_LOAD && comp_ok) begin
      lim_mem[lim_addr] <= in_ch.elem_a;
    end
    if (accept && in_ch.func == pvlc_pkg::FUNC_VEC) begin
      lim_q <= lim_mem[lim_addr];
    end
  end

  // Configuration registers and method table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_xl_r   <= '0;
      box_xh_r   <= 32'sh7fffffff;
      box_yl_r   <= '0;
      box_yh_r   <= 32'sh7fffffff;
      box_zl_r   <= '0;
      box_zh_r   <= 32'sh7fffffff;
      apply_in_r <= 1'b1;
      for (int i = 0; i < NUM_COMPONENTS; i++) meth_tab_r[i] <= pvlc_pkg::METH_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pvlc_pkg::REG_BOX_X_LOW:  box_xl_r   <= cfg_wdata;
          pvlc_pkg::REG_BOX_X_HIGH: box_xh_r   <= cfg_wdata;
          pvlc_pkg::REG_BOX_Y_LOW:  box_yl_r   <= cfg_wdata;
          pvlc_pkg::REG_BOX_Y_HIGH: box_yh_r   <= cfg_wdata;
          pvlc_pkg::REG_BOX_Z_LOW:  box_zl_r   <= cfg_wdata;
          pvlc_pkg::REG_BOX_Z_HIGH: box_zh_r   <= cfg_wdata;
          pvlc_pkg::REG_APPLY_IN:   apply_in_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      // Methods outside the legal codes store as no action.
      if (accept && in_ch.func == pvlc_pkg::FUNC_LOAD && comp_ok) begin
        meth_tab_r[comp_idx] <= (in_ch.elem_b[31:2] == '0) ? in_ch.elem_b[1:0]
                                                          : pvlc_pkg::METH_NONE;
      end
    end
  end

  // Sequencer, particle flags and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      force_ex_r  <= 1'b0;
      torque_ex_r <= 1'b0;
      any_ex_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sel_r       <= '0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_ch.func == pvlc_pkg::FUNC_POS) begin
            active_r    <= in_box == apply_in_r;
            force_ex_r  <= 1'b0;
            torque_ex_r <= 1'b0;
            any_ex_r    <= 1'b0;
          end else if (accept && in_ch.func == pvlc_pkg::FUNC_VEC) begin
            cnt_r <= '0;
            if (active_r && comp_ok && meth_tab_r[comp_idx] != pvlc_pkg::METH_NONE)
              state_r <= ST_MAG;
            else
              state_r <= ST_FINISH;
          end
        end
        ST_MAG: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            if (exceeds) begin
              if (kind_r == pvlc_pkg::KIND_FORCE)  force_ex_r  <= 1'b1;
              if (kind_r == pvlc_pkg::KIND_TORQUE) torque_ex_r <= 1'b1;
              any_ex_r <= 1'b1;
            end
            sel_r   <= '0;
            state_r <= do_scale ? ST_ROOT : ST_FINISH;
          end
        end
        ST_ROOT: if (root_done) state_r <= ST_MULC;
        ST_MULC: state_r <= ST_DIVS;
        ST_DIVS: state_r <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            sel_r   <= sel_r + 2'd1;
            state_r <= (sel_r == 2'd2) ? ST_FINISH : ST_MULC;
          end
        end
        ST_FINISH: begin
          if (can_load) begin
            if (last) begin
              active_r    <= 1'b0;
              force_ex_r  <= 1'b0;
              torque_ex_r <= 1'b0;
              any_ex_r    <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && in_ch.func == pvlc_pkg::FUNC_VEC) begin
      va_r     <= in_ch.elem_a;
      vb_r     <= in_ch.elem_b;
      vc_r     <= in_ch.elem_c;
      ra_r     <= in_ch.elem_a;
      rb_r     <= in_ch.elem_b;
      rc_r     <= in_ch.elem_c;
      kind_r   <= in_ch.kind;
      meth_r   <= (active_r && comp_ok) ? meth_tab_r[comp_idx] : pvlc_pkg::METH_NONE;
      scaled_r <= 1'b0;
      drop_r   <= 1'b0;
    end
    if (state_r == ST_MAG) begin
      // Sum of squares accumulates one product behind the multiplier.
      if (cnt_r == 3'd0) acc_r <= '0;
      else if (cnt_r != 3'd4) acc_r <= acc_r + prod;
      if (cnt_r == 3'd4) begin
        scaled_r <= do_scale;
        drop_r   <= (meth_r == pvlc_pkg::METH_DELETE) && last && (any_ex_r || exceeds);
      end
    end
    if (state_r == ST_DIVW && div_done) begin
      case (sel_r)
        2'd0:    ra_r <= q_signed;
        2'd1:    rb_r <= q_signed;
        default: rc_r <= q_signed;
      endcase
    end
    if (state_r == ST_FINISH && can_load) begin
      o_kind_r   <= kind_r;
      o_a_r      <= ra_r;
      o_b_r      <= rb_r;
      o_c_r      <= rc_r;
      o_scaled_r <= scaled_r;
      o_drop_r   <= drop_r;
      o_last_r   <= last;
    end
  end

  assign in_ch.ready             = state_r == ST_IDLE;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_kind         = o_kind_r;
  assign out_ch.out_a            = o_a_r;
  assign out_ch.out_b            = o_b_r;
  assign out_ch.out_c            = o_c_r;
  assign out_ch.was_scaled       = o_scaled_r;
  assign out_ch.drop_particle    = o_drop_r;
  assign out_ch.last_of_particle = o_last_r;

endmodule

FILE: rtl/pvlc_checker.sv
// Port checker of the particle vector limit clamp and its bind to the top level.
module pvlc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       was_scaled,
  input logic       drop_particle,
  input logic       last_of_particle
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A vector beat occupies the block for at least the next cycle.
  a_vec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == pvlc_pkg::FUNC_VEC |=> !in_ready)
    else $error("input taken right after a vector beat");

  // The particle end mark follows the angular momentum kind.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last_of_particle == (out_kind == pvlc_pkg::KIND_ANGMOM))
    else $error("end mark does not match kind");

  // Deletion never comes with a rescale.
  a_drop_noscale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(was_scaled && drop_particle))
    else $error("rescaled vector flagged for deletion");

endmodule

bind particle_vector_limit_clamp_top pvlc_checker u_pvlc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_func(in_ch.func),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_kind(out_ch.out_kind),
  .was_scaled(out_ch.was_scaled),
  .drop_particle(out_ch.drop_particle),
  .last_of_particle(out_ch.last_of_particle)
);
